[sv/rmq_pkg.sv]
// Shared types and constants for the rotation-matrix-to-quaternion block.
// No dependencies; imported by every module of the block.
package rmq_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 14;

   // off-diagonal sums / differences and their magnitudes
   localparam int SUM_WIDTH = DATA_WIDTH + 1;
   localparam int MAG_WIDTH = SUM_WIDTH;
   // classification arithmetic, wide enough for 1 + three entries
   localparam int CLS_WIDTH = DATA_WIDTH + 3;
   // positive radicand
   localparam int RAD_WIDTH = DATA_WIDTH + 1;

   // square root of rad * 2^(FRAC_BITS+2)
   localparam int SQ_IN_WIDTH  = RAD_WIDTH + FRAC_BITS + 2;
   localparam int ROOT_WIDTH   = (SQ_IN_WIDTH + 1) / 2;
   localparam int SQ_PAD_WIDTH = 2 * ROOT_WIDTH;
   localparam int SQ_REM_WIDTH = ROOT_WIDTH + 3;

   // scaled division
   localparam int NUM_WIDTH     = MAG_WIDTH + FRAC_BITS + 1;
   localparam int DIV_REM_WIDTH = ROOT_WIDTH + DATA_WIDTH;
   localparam int LANES         = 3;

   // front-to-back queue
   localparam int QDEPTH      = 4;
   localparam int QPTR_WIDTH  = 2;
   localparam int QCNT_WIDTH  = 3;

   typedef enum logic [1:0] {
      COMP_X = 2'd0,
      COMP_Y = 2'd1,
      COMP_Z = 2'd2,
      COMP_W = 2'd3
   } comp_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] m00;
      logic signed [DATA_WIDTH-1:0] m01;
      logic signed [DATA_WIDTH-1:0] m02;
      logic signed [DATA_WIDTH-1:0] m10;
      logic signed [DATA_WIDTH-1:0] m11;
      logic signed [DATA_WIDTH-1:0] m12;
      logic signed [DATA_WIDTH-1:0] m20;
      logic signed [DATA_WIDTH-1:0] m21;
      logic signed [DATA_WIDTH-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] qx;
      logic signed [DATA_WIDTH-1:0] qy;
      logic signed [DATA_WIDTH-1:0] qz;
      logic signed [DATA_WIDTH-1:0] qw;
      logic                         bad_input;
   } rsp_type;

   // classified request as it leaves the front
   typedef struct packed {
      comp_type                    dom;
      logic                        bad;
      logic [RAD_WIDTH-1:0]        rad;
      logic signed [SUM_WIDTH-1:0] s1;
      logic signed [SUM_WIDTH-1:0] s2;
      logic signed [SUM_WIDTH-1:0] s3;
   } item_type;

   typedef struct packed {
      logic                    valid;
      item_type                item;
      logic [SQ_REM_WIDTH-1:0] rem;
      logic [ROOT_WIDTH-1:0]   root;
   } sq_stage_type;

   typedef struct packed {
      logic                                  valid;
      comp_type                              dom;
      logic                                  bad;
      logic [ROOT_WIDTH-1:0]                 root;
      logic [LANES-1:0]                      neg;
      logic [LANES-1:0]                      ovf;
      logic [LANES-1:0][DIV_REM_WIDTH-1:0]   rem;
      logic [LANES-1:0][DATA_WIDTH-1:0]      quo;
   } div_stage_type;

   // front/back handshake
   typedef struct packed {
      logic valid;
      logic take;
   } qctl_type;

endpackage

[sv/rotation_matrix_to_quaternion.sv]
// Top level: rotation matrix (Q2.14) to quaternion x,y,z,w, Shepperd's method.
// From request accept to the rsp ports: 18 root stages, 17 divider stages
// and the output register.
// Throughput: one request per cycle; every stage is pipelined, a held result stalls all.
// A 4-entry queue sits between classifier and the stallable arithmetic pipeline.
// Synchronous active-high reset empties queue and pipeline; no other state.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  logic    push,
   output logic    full,
   output rsp_type rsp_data,
   output logic    empty,
   input  logic    pop
);

   item_type head;
   logic     head_valid;
   qctl_type qctl;

   rmq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .req_push   (push),
      .req_full   (full),
      .head       (head),
      .head_valid (head_valid),
      .take       (qctl.take)
   );

   rmq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qctl       (qctl),
      .head_valid (head_valid),
      .rsp_pop    (pop),
      .rsp_empty  (empty),
      .rsp_data   (rsp_data)
   );

endmodule

[sv/rmq_front.sv]
// Front: picks the branch, forms radicand and off-diagonal terms, and queues
// the classified request for the back. Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  logic     req_push,
   output logic     req_full,
   output item_type head,
   output logic     head_valid,
   input  logic     take
);

   localparam logic signed [CLS_WIDTH-1:0] ONE = CLS_WIDTH'(1) << FRAC_BITS;

   function automatic logic signed [SUM_WIDTH-1:0] sadd(
      input logic signed [DATA_WIDTH-1:0] a, input logic signed [DATA_WIDTH-1:0] b);
      return SUM_WIDTH'(a) + SUM_WIDTH'(b);
   endfunction

   function automatic logic signed [SUM_WIDTH-1:0] ssub(
      input logic signed [DATA_WIDTH-1:0] a, input logic signed [DATA_WIDTH-1:0] b);
      return SUM_WIDTH'(a) - SUM_WIDTH'(b);
   endfunction

   logic signed [CLS_WIDTH-1:0] e00, e11, e22, trace, rad_full;
   item_type cls;

   always_comb begin
      e00   = CLS_WIDTH'(req_data.m00);
      e11   = CLS_WIDTH'(req_data.m11);
      e22   = CLS_WIDTH'(req_data.m22);
      trace = e00 + e11 + e22;
      cls   = '0;
      if (trace > 0) begin
         rad_full = ONE + trace;
         cls.dom  = COMP_W;
         cls.s1   = ssub(req_data.m12, req_data.m21);
         cls.s2   = ssub(req_data.m20, req_data.m02);
         cls.s3   = ssub(req_data.m01, req_data.m10);
      end else if (e00 > e11 && e00 > e22) begin
         rad_full = ONE + e00 - e11 - e22;
         cls.dom  = COMP_X;
         cls.s1   = sadd(req_data.m10, req_data.m01);
         cls.s2   = sadd(req_data.m20, req_data.m02);
         cls.s3   = ssub(req_data.m12, req_data.m21);
      end else if (e11 > e22) begin
         rad_full = ONE + e11 - e00 - e22;
         cls.dom  = COMP_Y;
         cls.s1   = sadd(req_data.m10, req_data.m01);
         cls.s2   = sadd(req_data.m21, req_data.m12);
         cls.s3   = ssub(req_data.m20, req_data.m02);
      end else begin
         rad_full = ONE + e22 - e00 - e11;
         cls.dom  = COMP_Z;
         cls.s1   = sadd(req_data.m20, req_data.m02);
         cls.s2   = sadd(req_data.m21, req_data.m12);
         cls.s3   = ssub(req_data.m01, req_data.m10);
      end
      cls.bad = (rad_full <= 0);
      cls.rad = cls.bad ? '0 : rad_full[RAD_WIDTH-1:0];
   end

   // request queue
   item_type                mem_ff [QDEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;
   logic                    push_ok;

   assign req_full   = (count_ff == QCNT_WIDTH'(QDEPTH));
   assign push_ok    = req_push && !req_full;
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !take) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_WIDTH'(QDEPTH)) else $error("queue count over depth");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      take |-> head_valid) else $error("take from empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !take) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance");

endmodule

[sv/rmq_back.sv]
// Back: pipelined square root, three pipelined scaled dividers, saturation
// and the result register. Depends on rmq_pkg.
module rmq_back import rmq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  item_type head,
   output qctl_type qctl,
   input  logic     head_valid,
   input  logic     rsp_pop,
   output logic     rsp_empty,
   output rsp_type  rsp_data
);

   localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic    out_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    en;

   // whole pipeline advances unless a finished result is held
   assign en         = !out_valid_ff || rsp_pop;
   assign qctl.valid = head_valid;
   assign qctl.take  = en && head_valid;
   assign rsp_empty  = !out_valid_ff;
   assign rsp_data   = rsp_ff;

   // square root, one root bit per stage
   sq_stage_type sq_ff [ROOT_WIDTH+1];
   sq_stage_type sq_in [ROOT_WIDTH+1];

   always_comb begin
      sq_in[0]       = '0;
      sq_in[0].valid = qctl.take;
      sq_in[0].item  = head;
   end

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_sq
      localparam int BIT = ROOT_WIDTH - 1 - k;
      logic [SQ_PAD_WIDTH-1:0]   x;
      logic [SQ_REM_WIDTH+1:0]   rem_n, trial;
      always_comb begin
         x     = SQ_PAD_WIDTH'({sq_ff[k].item.rad, (FRAC_BITS+2)'(0)});
         rem_n = {sq_ff[k].rem, x[2*BIT+1 -: 2]};
         trial = (SQ_REM_WIDTH+2)'({sq_ff[k].root, 2'b01});
         sq_in[k+1] = sq_ff[k];
         if (rem_n >= trial) begin
            sq_in[k+1].rem  = SQ_REM_WIDTH'(rem_n - trial);
            sq_in[k+1].root = {sq_ff[k].root[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            sq_in[k+1].rem  = SQ_REM_WIDTH'(rem_n);
            sq_in[k+1].root = {sq_ff[k].root[ROOT_WIDTH-2:0], 1'b0};
         end
      end
   end

   // division prep: magnitude, rounding offset, overflow check
   div_stage_type div_ff [DATA_WIDTH+1];
   div_stage_type div_in [DATA_WIDTH+1];

   always_comb begin
      logic signed [SUM_WIDTH-1:0] s;
      logic [MAG_WIDTH-1:0]        mag;
      logic [NUM_WIDTH-1:0]        num;
      sq_stage_type                src;
      src            = sq_ff[ROOT_WIDTH];
      div_in[0]      = '0;
      div_in[0].valid = src.valid;
      div_in[0].dom  = src.item.dom;
      div_in[0].bad  = src.item.bad;
      div_in[0].root = src.root;
      for (int l = 0; l < LANES; l++) begin
         s   = (l == 0) ? src.item.s1 : (l == 1) ? src.item.s2 : src.item.s3;
         mag = s[SUM_WIDTH-1] ? MAG_WIDTH'(-s) : MAG_WIDTH'(s);
         num = NUM_WIDTH'({mag, FRAC_BITS'(0)}) + NUM_WIDTH'(src.root >> 1);
         div_in[0].neg[l] = s[SUM_WIDTH-1];
         div_in[0].rem[l] = DIV_REM_WIDTH'(num);
         div_in[0].ovf[l] = DIV_REM_WIDTH'(num) >= (DIV_REM_WIDTH'(src.root) << DATA_WIDTH);
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < DATA_WIDTH; j++) begin : g_div
      localparam int BIT = DATA_WIDTH - 1 - j;
      logic [DIV_REM_WIDTH-1:0] d;
      always_comb begin
         d = DIV_REM_WIDTH'(div_ff[j].root) << BIT;
         div_in[j+1] = div_ff[j];
         for (int l = 0; l < LANES; l++) begin
            if (div_ff[j].rem[l] >= d) begin
               div_in[j+1].rem[l] = div_ff[j].rem[l] - d;
               div_in[j+1].quo[l] = {div_ff[j].quo[l][DATA_WIDTH-2:0], 1'b1};
            end else begin
               div_in[j+1].quo[l] = {div_ff[j].quo[l][DATA_WIDTH-2:0], 1'b0};
            end
         end
      end
   end

   function automatic logic [DATA_WIDTH-1:0] sat_lane(
      input logic neg, input logic ovf, input logic [DATA_WIDTH-1:0] quo);
      if (!neg) begin
         return (ovf || quo[DATA_WIDTH-1]) ? SAT_MAX : quo;
      end
      return (ovf || quo > SAT_MIN) ? SAT_MIN : DATA_WIDTH'(-quo);
   endfunction

   // saturate and place components; a bad input gives zeros and the flag
   always_comb begin
      logic [ROOT_WIDTH:0]          dsum;
      logic [DATA_WIDTH-1:0]        dval;
      logic [LANES-1:0][DATA_WIDTH-1:0] lv;
      div_stage_type                fin;
      fin  = div_ff[DATA_WIDTH];
      dsum = ((ROOT_WIDTH+1)'(fin.root) + (ROOT_WIDTH+1)'(2)) >> 2;
      dval = (dsum > (ROOT_WIDTH+1)'(SAT_MAX)) ? SAT_MAX : dsum[DATA_WIDTH-1:0];
      for (int l = 0; l < LANES; l++) begin
         lv[l] = sat_lane(fin.neg[l], fin.ovf[l], fin.quo[l]);
      end
      rsp_in = '0;
      case (fin.dom)
         COMP_X: begin
            rsp_in.qx = dval;  rsp_in.qy = lv[0]; rsp_in.qz = lv[1]; rsp_in.qw = lv[2];
         end
         COMP_Y: begin
            rsp_in.qx = lv[0]; rsp_in.qy = dval;  rsp_in.qz = lv[1]; rsp_in.qw = lv[2];
         end
         COMP_Z: begin
            rsp_in.qx = lv[0]; rsp_in.qy = lv[1]; rsp_in.qz = dval;  rsp_in.qw = lv[2];
         end
         default: begin
            rsp_in.qx = lv[0]; rsp_in.qy = lv[1]; rsp_in.qz = lv[2]; rsp_in.qw = dval;
         end
      endcase
      if (fin.bad) begin
         rsp_in           = '0;
         rsp_in.bad_input = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ROOT_WIDTH; k++) begin
            sq_ff[k].valid <= 1'b0;
         end
         for (int j = 0; j <= DATA_WIDTH; j++) begin
            div_ff[j].valid <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         sq_ff[0] <= sq_in[0];
         for (int k = 0; k < ROOT_WIDTH; k++) begin
            sq_ff[k+1] <= sq_in[k+1];
         end
         for (int j = 0; j <= DATA_WIDTH; j++) begin
            div_ff[j] <= div_in[j];
         end
         out_valid_ff <= div_ff[DATA_WIDTH].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ff.bad_input) |->
         (rsp_ff.qx == '0 && rsp_ff.qy == '0 && rsp_ff.qz == '0 && rsp_ff.qw == '0))
      else $error("flagged result has nonzero components");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      qctl.take |-> sq_in[0].valid) else $error("take without load");

endmodule

[dv/tb_rotation_matrix_to_quaternion.sv]
// Testbench for rotation_matrix_to_quaternion: directed table plus random matrices,
// checked against an integer predictor of the fixed-point conversion.
// Depends on rmq_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
   import rmq_pkg::*;

   localparam int N_RANDOM   = 1200;
   localparam int DOG_LIMIT  = 20000;
   localparam int DRAIN_CYC  = 60;

   logic    clock;
   logic    reset;
   req_type req_data;
   logic    push;
   logic    full;
   rsp_type rsp_data;
   logic    empty;
   logic    pop;

   rsp_type quat_expected[$];
   int      err_count;
   int      idle_cycles;

   typedef struct {
      req_type m;
      bit      typed;   // expected result typed in below
      rsp_type q;
   } dir_row_type;

   rotation_matrix_to_quaternion i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .push     (push),
      .full     (full),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // floor(sqrt(v)) for v < 2^40
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd1 << 21;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic longint sat_word(longint v);
      longint hi, lo;
      hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // s * 2^FRAC_BITS / den, ties away from zero
   function automatic longint round_div(longint s, longint den);
      longint mag, q;
      mag = (s < 0) ? -s : s;
      q = ((mag <<< FRAC_BITS) + den / 2) / den;
      return (s < 0) ? -q : q;
   endfunction

   function automatic rsp_type quat_from_matrix(req_type m);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
      longint tr, rad, s1, s2, s3, root;
      longint comp[4];
      longint sums[3];
      comp_type dom;
      int n;
      rsp_type q;
      a00 = m.m00; a01 = m.m01; a02 = m.m02;
      a10 = m.m10; a11 = m.m11; a12 = m.m12;
      a20 = m.m20; a21 = m.m21; a22 = m.m22;
      tr = a00 + a11 + a22;
      if (tr > 0) begin
         rad = (64'sd1 <<< FRAC_BITS) + tr; dom = COMP_W;
         s1 = a12 - a21; s2 = a20 - a02; s3 = a01 - a10;
      end else if (a00 > a11 && a00 > a22) begin
         rad = (64'sd1 <<< FRAC_BITS) + a00 - a11 - a22; dom = COMP_X;
         s1 = a10 + a01; s2 = a20 + a02; s3 = a12 - a21;
      end else if (a11 > a22) begin
         rad = (64'sd1 <<< FRAC_BITS) + a11 - a00 - a22; dom = COMP_Y;
         s1 = a10 + a01; s2 = a21 + a12; s3 = a20 - a02;
      end else begin
         rad = (64'sd1 <<< FRAC_BITS) + a22 - a00 - a11; dom = COMP_Z;
         s1 = a20 + a02; s2 = a21 + a12; s3 = a01 - a10;
      end
      q = '0;
      if (rad <= 0) begin
         q.bad_input = 1'b1;
         return q;
      end
      root = int_sqrt(rad << (FRAC_BITS + 2));
      sums[0] = s1; sums[1] = s2; sums[2] = s3;
      n = 0;
      for (int j = 0; j < 4; j++) begin
         if (j == int'(dom)) comp[j] = sat_word((root + 2) >>> 2);
         else begin
            comp[j] = sat_word(round_div(sums[n], root));
            n++;
         end
      end
      q.qx = DATA_WIDTH'(comp[0]);
      q.qy = DATA_WIDTH'(comp[1]);
      q.qz = DATA_WIDTH'(comp[2]);
      q.qw = DATA_WIDTH'(comp[3]);
      return q;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      err_count++;
   endtask

   function automatic req_type mat(int v00, int v01, int v02, int v10, int v11,
                                   int v12, int v20, int v21, int v22);
      req_type m;
      m.m00 = DATA_WIDTH'(v00); m.m01 = DATA_WIDTH'(v01); m.m02 = DATA_WIDTH'(v02);
      m.m10 = DATA_WIDTH'(v10); m.m11 = DATA_WIDTH'(v11); m.m12 = DATA_WIDTH'(v12);
      m.m20 = DATA_WIDTH'(v20); m.m21 = DATA_WIDTH'(v21); m.m22 = DATA_WIDTH'(v22);
      return m;
   endfunction

   function automatic rsp_type quat(int x, int y, int z, int w, bit bad);
      rsp_type q;
      q.qx = DATA_WIDTH'(x); q.qy = DATA_WIDTH'(y);
      q.qz = DATA_WIDTH'(z); q.qw = DATA_WIDTH'(w);
      q.bad_input = bad;
      return q;
   endfunction

   function automatic int short_or_long_gap();
      if ($urandom_range(99) < 50) return 0;
      if ($urandom_range(99) < 90) return $urandom_range(3);
      return $urandom_range(40);
   endfunction

   // rotation-like matrix: near-orthonormal with random perturbation, or (one in five) fully random bits
   function automatic req_type random_matrix();
      req_type m;
      int pick;
      int unit;
      pick = $urandom_range(9);
      if (pick < 2) begin
         m = req_type'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      end else begin
         unit = 16384;
         m = mat(0, 0, 0, 0, 0, 0, 0, 0, 0);
         case ($urandom_range(3))
            0: m = mat(unit, 0, 0, 0, unit, 0, 0, 0, unit);
            1: m = mat(unit, 0, 0, 0, -unit, 0, 0, 0, -unit);
            2: m = mat(-unit, 0, 0, 0, unit, 0, 0, 0, -unit);
            default: m = mat(-unit, 0, 0, 0, -unit, 0, 0, 0, unit);
         endcase
         m.m00 += DATA_WIDTH'(int'($urandom_range(8000)) - 4000);
         m.m01 += DATA_WIDTH'(int'($urandom_range(16000)) - 8000);
         m.m02 += DATA_WIDTH'(int'($urandom_range(16000)) - 8000);
         m.m10 += DATA_WIDTH'(int'($urandom_range(16000)) - 8000);
         m.m11 += DATA_WIDTH'(int'($urandom_range(8000)) - 4000);
         m.m12 += DATA_WIDTH'(int'($urandom_range(16000)) - 8000);
         m.m20 += DATA_WIDTH'(int'($urandom_range(16000)) - 8000);
         m.m21 += DATA_WIDTH'(int'($urandom_range(16000)) - 8000);
         m.m22 += DATA_WIDTH'(int'($urandom_range(8000)) - 4000);
      end
      return m;
   endfunction

   // push stays high across back-to-back requests; it drops only for a gap
   task automatic send_request(req_type m);
      int gap;
      gap = short_or_long_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= m;
      push     <= 1'b1;
      quat_expected.push_back(quat_from_matrix(m));
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   task automatic send_typed(req_type m, rsp_type q);
      rsp_type p;
      p = quat_from_matrix(m);
      if (p.qx !== q.qx) report_mismatch("directed qx", p.qx, q.qx);
      if (p.qy !== q.qy) report_mismatch("directed qy", p.qy, q.qy);
      if (p.qz !== q.qz) report_mismatch("directed qz", p.qz, q.qz);
      if (p.qw !== q.qw) report_mismatch("directed qw", p.qw, q.qw);
      if (p.bad_input !== q.bad_input)
         report_mismatch("directed bad_input", p.bad_input, q.bad_input);
      send_request(m);
   endtask

   // result side: random pop stalls
   initial begin
      int stall;
      rsp_type want;
      pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = short_or_long_gap();
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         if (!empty) begin
            if (quat_expected.size() == 0) begin
               $display("MISMATCH unexpected result");
               err_count++;
            end else begin
               want = quat_expected.pop_front();
               if (rsp_data.qx !== want.qx) report_mismatch("qx", rsp_data.qx, want.qx);
               if (rsp_data.qy !== want.qy) report_mismatch("qy", rsp_data.qy, want.qy);
               if (rsp_data.qz !== want.qz) report_mismatch("qz", rsp_data.qz, want.qz);
               if (rsp_data.qw !== want.qw) report_mismatch("qw", rsp_data.qw, want.qw);
               if (rsp_data.bad_input !== want.bad_input)
                  report_mismatch("bad_input", rsp_data.bad_input, want.bad_input);
            end
         end
         @(negedge clock);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= DOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      dir_row_type rows[$];
      dir_row_type r;
      int wait_cyc;
      err_count   = 0;
      reset       = 1'b1;
      push        = 1'b0;
      req_data    = '0;

      r.typed = 1; r.m = mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
      r.q = quat(0, 0, 0, 16384, 0); rows.push_back(r);
      r.m = mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
      r.q = quat(16384, 0, 0, 0, 0); rows.push_back(r);
      r.m = mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
      r.q = quat(0, 16384, 0, 0, 0); rows.push_back(r);
      r.m = mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
      r.q = quat(0, 0, 16384, 0, 0); rows.push_back(r);
      // equal diagonals fall through to the z branch; radicand stays positive
      r.m = mat(0, 0, 0, 0, 0, 0, 0, 0, 0);
      r.q = quat(0, 0, 8192, 0, 0); rows.push_back(r);
      r.m = mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768);
      r.q = quat(0, 0, 14189, 0, 0); rows.push_back(r);
      // ties between diagonal entries fall to later branches
      r.m = mat(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
      r.q = quat(0, 0, 11585, 0, 0); rows.push_back(r);
      r.typed = 0;
      r.m = mat(-8192, 100, -100, 200, -8192, 300, -300, 400, -8192); rows.push_back(r);
      r.m = mat(-4000, 500, 600, 700, -4000, 800, 900, 1000, -8000); rows.push_back(r);
      // saturation and extremes
      r.m = mat(32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768, 32767);
      rows.push_back(r);
      r.m = mat(1, 32767, 32767, 32767, 0, 32767, 32767, 32767, 0); rows.push_back(r);
      r.m = mat(0, -32768, -32768, -32768, -1, -32768, -32768, -32768, -1); rows.push_back(r);
      r.m = mat(-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768, 32767);
      rows.push_back(r);
      r.m = mat(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, -32768);
      rows.push_back(r);
      r.m = mat(-16383, -32768, 32767, 32767, -1, -32768, -32768, 32767, -1);
      rows.push_back(r);
      r.m = mat(11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384); rows.push_back(r);
      r.m = mat(-1, -1, -1, -1, -1, -1, -1, -1, -1); rows.push_back(r);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         if (rows[i].typed) send_typed(rows[i].m, rows[i].q);
         else send_request(rows[i].m);
      end
      for (int i = 0; i < N_RANDOM; i++) send_request(random_matrix());
      push <= 1'b0;

      wait_cyc = 0;
      while (quat_expected.size() != 0 && wait_cyc < DOG_LIMIT) begin
         @(posedge clock);
         wait_cyc++;
      end
      repeat (DRAIN_CYC) @(posedge clock);
      if (err_count == 0 && quat_expected.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_back.sv
sv/rotation_matrix_to_quaternion.sv
dv/tb_rotation_matrix_to_quaternion.sv
